// ----- hdl/epr_pkg.sv -----
// Shared types and constants for the echo pulse ranging median filter.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps

package epr_pkg;

  localparam int CHANNELS_DEF = 3;
  localparam int CHAN_W       = 2;
  localparam int TIME_W       = 16;
  localparam int DIST_W       = 16;
  localparam int SET_SIZE     = 4;
  localparam int SLOT_W       = 2;   // bits that index a sample within a set

  // Speed of sound scale 340000/200000 reduces to 17/10.
  localparam int SCALE_NUM    = 17;
  localparam int WIDE_W       = 21;  // width * 17 fits in 21 bits
  localparam logic [WIDE_W-1:0] SAT_LIMIT = WIDE_W'(655360);  // 65536 * 10

  // floor(x/10) == (x * RECIP) >> RECIP_SHIFT for every x below 2^22
  localparam int RECIP_W      = 20;
  localparam int RECIP_SHIFT  = 23;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(838861);

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [TIME_W-1:0] capture_time;
  } cap_t;

  typedef struct packed {
    logic [CHAN_W-1:0] source_channel;
    logic              pulse_done;
    logic [DIST_W-1:0] pulse_distance;
    logic              median_ready;
    logic [DIST_W-1:0] filtered_distance;
  } res_t;

  typedef enum logic [2:0] {
    ALU_SUB,     // 16-bit wrapping a - b
    ALU_MUL17,   // a * 17, full width
    ALU_DIV10,   // floor(a / 10) saturated to 16 bits
    ALU_MINMAX,  // lo = min, hi = max
    ALU_AVG      // floor((a + b) / 2)
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [WIDE_W-1:0] a;
    logic [DIST_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [WIDE_W-1:0] wide;
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
  } alu_res_t;

endpackage

// ----- hdl/epr_alu.sv -----
// Shared arithmetic unit: subtract, scale by 17, divide by 10, min/max, average.
// Depends on epr_pkg.
`timescale 1ns / 1ps

module epr_alu (
  input  epr_pkg::alu_req_t req,
  output epr_pkg::alu_res_t res
);

  localparam int PROD_W = epr_pkg::WIDE_W + epr_pkg::RECIP_W;

  logic [PROD_W-1:0]           prod;
  logic [epr_pkg::DIST_W:0]    sum;
  logic [epr_pkg::DIST_W-1:0]  a16;

  assign a16  = req.a[epr_pkg::DIST_W-1:0];
  assign prod = PROD_W'(req.a) * PROD_W'(epr_pkg::RECIP);
  assign sum  = {1'b0, a16} + {1'b0, req.b};

  always_comb begin
    res = '0;
    case (req.op)
      epr_pkg::ALU_SUB: begin
        res.lo = a16 - req.b;
      end
      epr_pkg::ALU_MUL17: begin
        // 17x = 16x + x
        res.wide = (epr_pkg::WIDE_W'(a16) << 4) + epr_pkg::WIDE_W'(a16);
      end
      epr_pkg::ALU_DIV10: begin
        if (req.a >= epr_pkg::SAT_LIMIT) begin
          res.lo = epr_pkg::DIST_MAX;
        end else begin
          res.lo = prod[epr_pkg::RECIP_SHIFT +: epr_pkg::DIST_W];
        end
      end
      epr_pkg::ALU_MINMAX: begin
        if (a16 > req.b) begin
          res.lo = req.b;
          res.hi = a16;
        end else begin
          res.lo = a16;
          res.hi = req.b;
        end
      end
      epr_pkg::ALU_AVG: begin
        res.lo = sum[epr_pkg::DIST_W:1];
      end
      default: begin
        res = '0;
      end
    endcase
    if (req.op != epr_pkg::ALU_MUL17) begin
      res.wide = epr_pkg::WIDE_W'(res.lo);
    end
  end

endmodule

// ----- hdl/epr_ctrl.sv -----
// Sequencer: per-channel edge state, sample memory and the median-of-four sort,
// all driven through one epr_alu. Depends on epr_pkg and epr_alu.
`timescale 1ns / 1ps

module epr_ctrl #(
  parameter int CHANNELS = epr_pkg::CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  epr_pkg::cap_t item,
  input  logic          slot_free,
  output logic          busy,
  output logic          done,
  output epr_pkg::res_t res
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = CHANNELS * epr_pkg::SET_SIZE;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SUB  = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_LOAD = 8'b0001_0000,
    S_SORT = 8'b0010_0000,
    S_AVG  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t state;

  logic [epr_pkg::CHAN_W-1:0] ch;
  logic [epr_pkg::TIME_W-1:0] t;
  logic [epr_pkg::TIME_W-1:0] rise_time;
  logic [CHANNELS-1:0]        awaiting_fall;
  logic [epr_pkg::SLOT_W-1:0] sample_count [CHANNELS];
  logic [epr_pkg::DIST_W-1:0] held_distance [CHANNELS];
  logic [epr_pkg::WIDE_W-1:0] acc;
  logic [epr_pkg::DIST_W-1:0] pulse_dist;
  logic [epr_pkg::DIST_W-1:0] v0, v1, v2, v3;
  logic [epr_pkg::SLOT_W-1:0] step;

  logic [epr_pkg::DIST_W-1:0] sample_store [DEPTH];
  logic [epr_pkg::DIST_W-1:0] rd_data;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;

  logic [CH_W-1:0] ch_idx;
  logic [CH_W-1:0] in_idx;
  logic            in_range;

  epr_pkg::alu_req_t alu_req;
  epr_pkg::alu_res_t alu_res;

  assign ch_idx   = CH_W'(ch);
  assign in_idx   = CH_W'(item.channel);
  assign in_range = int'(item.channel) < CHANNELS;
  assign rd_addr  = AW'({ch_idx, step});
  assign wr_addr  = AW'({ch_idx, sample_count[ch_idx]});
  assign busy     = state != S_IDLE;
  assign done     = (state == S_EMIT) && slot_free;

  epr_alu u_alu (
    .req(alu_req),
    .res(alu_res)
  );

  always_comb begin
    alu_req = '{op: epr_pkg::ALU_SUB, a: '0, b: '0};
    case (state)
      S_SUB: begin
        alu_req = '{op: epr_pkg::ALU_SUB, a: epr_pkg::WIDE_W'(t), b: rise_time};
      end
      S_MUL: begin
        alu_req = '{op: epr_pkg::ALU_MUL17, a: acc, b: '0};
      end
      S_DIV: begin
        alu_req = '{op: epr_pkg::ALU_DIV10, a: acc, b: '0};
      end
      S_SORT: begin
        // compare-exchange network: after four steps v0 is least, v3 greatest
        case (step)
          2'd0:    alu_req = '{op: epr_pkg::ALU_MINMAX, a: epr_pkg::WIDE_W'(v0), b: v1};
          2'd1:    alu_req = '{op: epr_pkg::ALU_MINMAX, a: epr_pkg::WIDE_W'(v2), b: v3};
          2'd2:    alu_req = '{op: epr_pkg::ALU_MINMAX, a: epr_pkg::WIDE_W'(v0), b: v2};
          default: alu_req = '{op: epr_pkg::ALU_MINMAX, a: epr_pkg::WIDE_W'(v1), b: v3};
        endcase
      end
      S_AVG: begin
        alu_req = '{op: epr_pkg::ALU_AVG, a: epr_pkg::WIDE_W'(v1), b: v2};
      end
      default: begin
        alu_req = '{op: epr_pkg::ALU_SUB, a: '0, b: '0};
      end
    endcase
  end

  // sample memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == S_DIV) begin
      sample_store[wr_addr] <= alu_res.lo;
    end
    rd_data <= sample_store[rd_addr];
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          ch <= item.channel;
          t  <= item.capture_time;
          if (!in_range) begin
            res <= '{source_channel: item.channel, default: '0};
          end else begin
            res <= '{source_channel: item.channel, pulse_done: 1'b0,
                     pulse_distance: '0, median_ready: 1'b0,
                     filtered_distance: held_distance[in_idx]};
          end
        end
      end
      S_SUB, S_MUL: begin
        acc <= alu_res.wide;
      end
      S_DIV: begin
        pulse_dist <= alu_res.lo;
        v3         <= alu_res.lo;
        res        <= '{source_channel: ch, pulse_done: 1'b1, pulse_distance: alu_res.lo,
                        median_ready: 1'b0, filtered_distance: held_distance[ch_idx]};
      end
      S_LOAD: begin
        case (step)
          2'd1:    v0 <= rd_data;
          2'd2:    v1 <= rd_data;
          2'd3:    v2 <= rd_data;
          default: v0 <= v0;
        endcase
      end
      S_SORT: begin
        case (step)
          2'd0: begin
            v0 <= alu_res.lo;
            v1 <= alu_res.hi;
          end
          2'd1: begin
            v2 <= alu_res.lo;
            v3 <= alu_res.hi;
          end
          2'd2: begin
            v0 <= alu_res.lo;
            v2 <= alu_res.hi;
          end
          default: begin
            v1 <= alu_res.lo;
            v3 <= alu_res.hi;
          end
        endcase
      end
      S_AVG: begin
        res <= '{source_channel: ch, pulse_done: 1'b1, pulse_distance: pulse_dist,
                 median_ready: 1'b1, filtered_distance: alu_res.lo};
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= '0;
      rise_time     <= '0;
      awaiting_fall <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        sample_count[i]  <= '0;
        held_distance[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            if (!in_range) begin
              state <= S_EMIT;
            end else if (!awaiting_fall[in_idx]) begin
              rise_time             <= item.capture_time;
              awaiting_fall[in_idx] <= 1'b1;
              state                 <= S_EMIT;
            end else begin
              awaiting_fall[in_idx] <= 1'b0;
              state                 <= S_SUB;
            end
          end
        end
        S_SUB: state <= S_MUL;
        S_MUL: state <= S_DIV;
        S_DIV: begin
          step <= '0;
          if (sample_count[ch_idx] == epr_pkg::SLOT_W'(epr_pkg::SET_SIZE - 1)) begin
            sample_count[ch_idx] <= '0;
            state                <= S_LOAD;
          end else begin
            sample_count[ch_idx] <= sample_count[ch_idx] + 1'b1;
            state                <= S_EMIT;
          end
        end
        S_LOAD: begin
          // read issued at step k lands in rd_data at step k+1
          step <= step + 1'b1;
          if (step == epr_pkg::SLOT_W'(epr_pkg::SET_SIZE - 1)) begin
            state <= S_SORT;
          end
        end
        S_SORT: begin
          step <= step + 1'b1;
          if (step == epr_pkg::SLOT_W'(epr_pkg::SET_SIZE - 1)) begin
            state <= S_AVG;
          end
        end
        S_AVG: begin
          held_distance[ch_idx] <= alu_res.lo;
          state                 <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fall_starts_calc: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && start && in_range && awaiting_fall[in_idx] |=> state == S_SUB)
    else $error("falling edge did not start the distance calculation");

  a_sorted_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_AVG |-> (v0 <= v1) && (v0 <= v2) && (v1 <= v3) && (v2 <= v3))
    else $error("sort network left the extremes in the middle");

  a_ready_needs_done: assert property (@(posedge clk) disable iff (rst)
    done && res.median_ready |-> res.pulse_done)
    else $error("median formed without a completed pulse");

  a_bad_channel_zero: assert property (@(posedge clk) disable iff (rst)
    done && (int'(res.source_channel) >= CHANNELS) |->
      !res.pulse_done && !res.median_ready && (res.filtered_distance == '0))
    else $error("result for an absent channel is not cleared");

endmodule

// ----- hdl/echo_pulse_range_median_filter_top.sv -----
// Channel    Dir  Payload          Handshake
// capture    in   epr_pkg::cap_t   capture_valid / capture_stall
// result     out  epr_pkg::res_t   result_valid  / result_stall
//
// Rising edge or absent channel: accept, then the emit state loads the
// result register once the slot is free; the next item is taken after that.
// Falling edge: subtract, scale, divide through the shared unit, then emit;
// a set's fourth sample adds four reads, four compare-exchanges, one average.
// One item at a time; the result register lets the next item enter while a
// result waits. Synchronous reset clears edge flags, counts and held distances.
// Depends on epr_pkg, epr_alu, epr_ctrl.
`timescale 1ns / 1ps

module echo_pulse_range_median_filter_top #(
  parameter int CHANNELS = epr_pkg::CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          capture_valid,
  output logic          capture_stall,
  input  epr_pkg::cap_t capture,
  output logic          result_valid,
  input  logic          result_stall,
  output epr_pkg::res_t result
);

  logic          busy;
  logic          done;
  logic          slot_free;
  epr_pkg::res_t res;

  assign capture_stall = busy;
  assign slot_free     = !result_valid || !result_stall;

  epr_ctrl #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (capture_valid && !busy),
    .item     (capture),
    .slot_free(slot_free),
    .busy     (busy),
    .done     (done),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result <= res;
    end
  end

endmodule
